### rtl/assert_macros.svh
// Assertion macros shared by the escaper RTL.
// Each macro expands to one labeled concurrent assertion, reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset
`define XE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define XE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle
`define XE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/xe_pkg.sv
// Package for the XML entity escaper: command types, entity text table,
// and shared lookup functions. No dependencies.
`timescale 1ns / 1ps

package xe_pkg;

    // Queue depth between front and back
    localparam int XE_QUEUE_DEPTH = 4;

    // Entity indexes into the text table
    localparam logic [1:0] ENT_LT   = 2'd0;
    localparam logic [1:0] ENT_GT   = 2'd1;
    localparam logic [1:0] ENT_AMP  = 2'd2;
    localparam logic [1:0] ENT_QUOT = 2'd3;

    // Characters the front classifies on
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;

    // Entity spellings, padded with zero
    localparam logic [7:0] ENT_TEXT [0:3][0:5] = '{
        '{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},   // &lt;
        '{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},   // &gt;
        '{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},   // &amp;
        '{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}    // &quot;
    };
    localparam logic [2:0] ENT_LEN [0:3] = '{3'd4, 3'd4, 3'd5, 3'd6};

    // What precedes the held letters in a transaction
    typedef enum logic [1:0] {
        LEAD_NONE,
        LEAD_AMP_CHAR,
        LEAD_AMP_ENT
    } t_lead;

    // How the trailing byte is written
    typedef enum logic [2:0] {
        TAIL_NONE,
        TAIL_RAW,
        TAIL_QUOT,
        TAIL_LT,
        TAIL_GT,
        TAIL_AMP
    } t_tail;

    // One queued output run: lead, held letters, tail
    typedef struct packed {
        t_lead            lead;
        logic [2:0]       held_n;
        logic [3:0][7:0]  held;
        t_tail            tail;
        logic [7:0]       tail_byte;
        logic             last_text;
    } t_cmd;

    function automatic logic [7:0] ent_char(input logic [1:0] e, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (idx < 3'd6) begin
            c = ENT_TEXT[e][idx];
        end
        return c;
    endfunction

endpackage

### rtl/xe_front.sv
// Front end of the escaper: accepts bytes, tracks a pending ampersand run
// and issues one run command per input that produces output. Uses xe_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_text,
    output logic          o_push,
    output xe_pkg::t_cmd  o_cmd
);
    import xe_pkg::*;

    logic [2:0]       r_held_count, n_held_count;
    logic [3:0]       r_match, n_match;
    logic [3:0][7:0]  r_held, n_held;

    logic [3:0]       cand_match;
    logic             full_hit;
    logic             prefix_hit;
    t_tail            fresh_tail;
    logic             fresh_hold;
    t_tail            plain_tail;

    // Plain escape class of the incoming byte
    always_comb begin
        priority if (i_in_byte == CH_QUOT) begin
            plain_tail = TAIL_QUOT;
        end else if (i_in_byte == CH_LT) begin
            plain_tail = TAIL_LT;
        end else if (i_in_byte == CH_GT) begin
            plain_tail = TAIL_GT;
        end else begin
            plain_tail = TAIL_RAW;
        end
    end

    // Byte seen with nothing held; an ampersand starts a hold unless it ends the text
    always_comb begin
        fresh_hold = 1'b0;
        if (i_in_byte == CH_AMP) begin
            fresh_tail = i_end_of_text ? TAIL_AMP : TAIL_NONE;
            fresh_hold = !i_end_of_text;
        end else begin
            fresh_tail = plain_tail;
        end
    end

    // Extend the per-entity prefix match by the new byte
    always_comb begin
        full_hit   = 1'b0;
        prefix_hit = 1'b0;
        for (int e = 0; e < 4; e++) begin
            cand_match[e] = r_match[e] && (r_held_count < ENT_LEN[e]) &&
                            (i_in_byte == ent_char(2'(e), r_held_count));
            if (cand_match[e] && (r_held_count == ENT_LEN[e] - 3'd1)) begin
                full_hit = 1'b1;
            end
            if (cand_match[e] && (r_held_count < ENT_LEN[e] - 3'd1)) begin
                prefix_hit = 1'b1;
            end
        end
    end

    // Decide the run and the next hold state
    always_comb begin
        n_held_count    = r_held_count;
        n_match         = r_match;
        n_held          = r_held;
        o_push          = 1'b0;
        o_cmd.lead      = LEAD_NONE;
        o_cmd.held_n    = r_held_count - 3'd1;
        o_cmd.held      = r_held;
        o_cmd.tail      = TAIL_RAW;
        o_cmd.tail_byte = i_in_byte;
        o_cmd.last_text = i_end_of_text;
        if (i_accept) begin
            if (r_held_count == 3'd0) begin
                o_cmd.held_n = 3'd0;
                o_cmd.tail   = fresh_tail;
                o_push       = !fresh_hold;
                if (fresh_hold) begin
                    n_held_count = 3'd1;
                    n_match      = '1;
                end
            end else if (full_hit) begin
                // complete entity passes through unchanged
                o_cmd.lead   = LEAD_AMP_CHAR;
                o_push       = 1'b1;
                n_held_count = 3'd0;
            end else if (prefix_hit && !i_end_of_text) begin
                n_held[2'(r_held_count - 3'd1)] = i_in_byte;
                n_held_count = r_held_count + 3'd1;
                n_match      = cand_match;
            end else if (prefix_hit) begin
                // text ends inside a partial entity
                o_cmd.lead   = LEAD_AMP_ENT;
                o_push       = 1'b1;
                n_held_count = 3'd0;
            end else begin
                // mismatch: flush held run, then treat the byte as fresh
                o_cmd.lead   = LEAD_AMP_ENT;
                o_cmd.tail   = fresh_tail;
                o_push       = 1'b1;
                n_held_count = 3'd0;
                if (fresh_hold) begin
                    n_held_count = 3'd1;
                    n_match      = '1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 3'd0;
            r_match      <= '0;
        end else begin
            r_held_count <= n_held_count;
            r_match      <= n_match;
        end
    end

    // Held letters carry no reset
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    `XE_ASSERT_ALWAYS(a_held_range, i_clk, i_rst_n, r_held_count <= 3'd5,
        "held count beyond longest entity prefix")
    `XE_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_accept && i_end_of_text,
        r_held_count == 3'd0, "hold survived end of text")

endmodule

### rtl/xe_fifo.sv
// Command queue between escaper front and back.
// Small register array with head/tail pointers. Uses xe_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xe_fifo #(
    parameter int DEPTH = xe_pkg::XE_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xe_pkg::t_cmd  i_cmd,
    input  logic          i_pop,
    output xe_pkg::t_cmd  o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import xe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `XE_ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, !o_full,
        "push into full command queue")
    `XE_ASSERT_IMPLIES(a_no_underflow, i_clk, i_rst_n, i_pop, !o_empty,
        "pop from empty command queue")

endmodule

### rtl/xe_back.sv
// Back end of the escaper: expands queued run commands into one output
// byte per cycle behind an output register, unless stalled. Uses xe_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  xe_pkg::t_cmd  i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_out_byte,
    output logic          o_run_last,
    output logic          o_text_done
);
    import xe_pkg::*;

    logic [3:0]  r_pos, n_pos;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic        r_run_last, n_run_last;
    logic        r_text_done, n_text_done;

    logic [2:0]  lead_len;
    logic [2:0]  tail_len;
    logic [3:0]  total;
    logic [3:0]  held_end;
    logic [3:0]  held_off;
    logic [3:0]  tail_off;
    logic [7:0]  cur_byte;
    logic        cur_last;
    logic        emit;

    // Segment lengths of the head command
    always_comb begin
        unique case (i_cmd.lead)
            LEAD_NONE:     lead_len = 3'd0;
            LEAD_AMP_CHAR: lead_len = 3'd1;
            LEAD_AMP_ENT:  lead_len = 3'd5;
            default:       lead_len = 3'd0;
        endcase
        unique case (i_cmd.tail)
            TAIL_NONE:     tail_len = 3'd0;
            TAIL_RAW:      tail_len = 3'd1;
            TAIL_QUOT:     tail_len = 3'd6;
            TAIL_LT:       tail_len = 3'd4;
            TAIL_GT:       tail_len = 3'd4;
            TAIL_AMP:      tail_len = 3'd5;
            default:       tail_len = 3'd0;
        endcase
        held_end = 4'(lead_len) + 4'(i_cmd.held_n);
        total    = held_end + 4'(tail_len);
        held_off = r_pos - 4'(lead_len);
        tail_off = r_pos - held_end;
    end

    // Byte at the current position of the run
    always_comb begin
        if (r_pos < 4'(lead_len)) begin
            cur_byte = (i_cmd.lead == LEAD_AMP_ENT) ? ent_char(ENT_AMP, r_pos[2:0]) : CH_AMP;
        end else if (r_pos < held_end) begin
            cur_byte = i_cmd.held[held_off[1:0]];
        end else begin
            unique case (i_cmd.tail)
                TAIL_RAW:  cur_byte = i_cmd.tail_byte;
                TAIL_QUOT: cur_byte = ent_char(ENT_QUOT, tail_off[2:0]);
                TAIL_LT:   cur_byte = ent_char(ENT_LT, tail_off[2:0]);
                TAIL_GT:   cur_byte = ent_char(ENT_GT, tail_off[2:0]);
                TAIL_AMP:  cur_byte = ent_char(ENT_AMP, tail_off[2:0]);
                TAIL_NONE: cur_byte = 8'h00;
                default:   cur_byte = 8'h00;
            endcase
        end
        cur_last = (r_pos == total - 4'd1);
    end

    // Step through the run whenever the output register can take a byte
    always_comb begin
        emit        = !i_empty && (!r_out_valid || !i_out_stall);
        o_pop       = emit && cur_last;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_byte  = r_out_byte;
        n_run_last  = r_run_last;
        n_text_done = r_text_done;
        if (emit) begin
            n_pos       = cur_last ? 4'd0 : r_pos + 4'd1;
            n_out_valid = 1'b1;
            n_out_byte  = cur_byte;
            n_run_last  = cur_last;
            n_text_done = cur_last && i_cmd.last_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_run_last  <= n_run_last;
        r_text_done <= n_text_done;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_text_done = r_text_done;

    `XE_ASSERT_IMPLIES(a_pos_in_run, i_clk, i_rst_n, !i_empty, r_pos < total,
        "run position past end of command")
    `XE_ASSERT_IMPLIES(a_idle_pos, i_clk, i_rst_n, i_empty, r_pos == 4'd0,
        "run position left mid-command with queue empty")

endmodule

### rtl/xml_entity_escaper.sv
// XML entity escaper: one raw byte per accepted transaction in, escaped bytes out.
// A run passes through the command queue and the output register, one run at a time.
// One input per cycle while the command queue is not full, and one output byte per
// cycle while the output is not stalled; up to QUEUE_DEPTH runs wait in the queue.
// Reset: synchronous active-low i_rst_n clears hold state, queue and output valid.
`timescale 1ns / 1ps

module xml_entity_escaper #(
    parameter int QUEUE_DEPTH = xe_pkg::XE_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic        o_text_done
);
    import xe_pkg::*;

    t_cmd  push_cmd;
    t_cmd  head_cmd;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    logic  accept;

    // Front stalls only on a full queue
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    xe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    xe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    xe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_done (o_text_done)
    );

endmodule

### sim/tb.sv
// Testbench for xml_entity_escaper: a directed table, then random strings
// checked against an in-bench escape predictor. Depends only on the RTL.
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 2000;    // cycles with no transaction at all
    localparam int HOLD_CYCLES = 200;     // long output hold-off
    localparam int PHASE_ITEMS = 100;

    // Characters the escaper acts on
    localparam logic [7:0] AMP   = 8'h26;
    localparam logic [7:0] QUOTE = 8'h22;
    localparam logic [7:0] LESS  = 8'h3C;
    localparam logic [7:0] MORE  = 8'h3E;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       i_end_of_text;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_text_done;

    xml_entity_escaper dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_end_of_text(i_end_of_text),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_run_last   (o_run_last),
        .o_text_done  (o_text_done)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // One expected output byte with its flags
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       done;
    } t_esc_byte;

    // Directed stimulus row; text is the expected run where typed in
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        bit         typed;
        string      text;
    } t_dir_row;

    string ent_spell [4] = '{"&lt;", "&gt;", "&amp;", "&quot;"};

    t_dir_row dir_rows [24] = '{
        '{8'h61, 1'b0, 1'b1, "a"},
        '{8'h00, 1'b0, 1'b0, ""},
        '{8'hFF, 1'b0, 1'b0, ""},
        '{QUOTE, 1'b0, 1'b1, "&quot;"},
        '{LESS,  1'b0, 1'b1, "&lt;"},
        '{MORE,  1'b1, 1'b1, "&gt;"},
        '{AMP,   1'b1, 1'b1, "&amp;"},         // ampersand as final byte
        '{AMP,   1'b0, 1'b1, ""},              // complete &lt; passes through
        '{"l",   1'b0, 1'b1, ""},
        '{"t",   1'b0, 1'b1, ""},
        '{";",   1'b0, 1'b1, "&lt;"},
        '{AMP,   1'b0, 1'b1, ""},              // &quot broken by a quote: longest run
        '{"q",   1'b0, 1'b1, ""},
        '{"u",   1'b0, 1'b1, ""},
        '{"o",   1'b0, 1'b1, ""},
        '{"t",   1'b0, 1'b1, ""},
        '{QUOTE, 1'b0, 1'b1, "&amp;quot&quot;"},
        '{AMP,   1'b0, 1'b1, ""},              // partial entity at end of text
        '{"a",   1'b0, 1'b1, ""},
        '{"m",   1'b1, 1'b1, "&amp;am"},
        '{AMP,   1'b0, 1'b1, ""},              // mismatch on a second ampersand
        '{"g",   1'b0, 1'b1, ""},
        '{AMP,   1'b0, 1'b1, "&amp;g"},
        '{"x",   1'b1, 1'b1, "&amp;x"}
    };

    // Predictor state
    logic [2:0] hold_len;
    logic [7:0] hold_buf [4];
    logic [7:0] run_q [$];
    t_esc_byte  esc_q [$];

    logic [7:0] txt_q [$];
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         hold_req;
    int         mismatches;
    int         quiet_cycles;

    task automatic emit_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) run_q = {run_q, s[i]};
    endtask

    task automatic emit_plain(input logic [7:0] b);
        case (b)
            QUOTE:   emit_str("&quot;");
            LESS:    emit_str("&lt;");
            MORE:    emit_str("&gt;");
            default: run_q = {run_q, b};
        endcase
    endtask

    // Byte seen with nothing held
    task automatic take_fresh(input logic [7:0] b, input logic eot);
        if (b == AMP) begin
            if (eot) emit_str("&amp;");
            else hold_len = 3'd1;
        end else begin
            emit_plain(b);
        end
    endtask

    // Escape one byte into run_q and advance the hold state
    task automatic escape_step(input logic [7:0] b, input logic eot);
        logic [7:0] cand [$];
        bit         full;
        bit         pfx;
        bit         hit;
        int         i;
        int         e;
        string      spell;
        if (hold_len == 3'd0) begin
            take_fresh(b, eot);
        end else begin
            cand = {cand, AMP};
            for (i = 1; i < hold_len; i++) cand = {cand, hold_buf[i-1]};
            cand = {cand, b};
            full = 1'b0;
            pfx  = 1'b0;
            for (e = 0; e < 4; e++) begin
                spell = ent_spell[e];
                if (cand.size() <= spell.len()) begin
                    hit = 1'b1;
                    foreach (cand[j]) if (cand[j] != spell[j]) hit = 1'b0;
                    if (hit && cand.size() == spell.len()) full = 1'b1;
                    else if (hit) pfx = 1'b1;
                end
            end
            if (full) begin
                foreach (cand[j]) run_q = {run_q, cand[j]};
                hold_len = 3'd0;
            end else if (pfx) begin
                if (eot) begin
                    emit_str("&amp;");
                    for (i = 1; i < cand.size(); i++) run_q = {run_q, cand[i]};
                    hold_len = 3'd0;
                end else begin
                    hold_buf[2'(hold_len - 3'd1)] = b;
                    hold_len = hold_len + 3'd1;
                end
            end else begin
                // broken match: flush the hold, then escape the breaking byte alone
                emit_str("&amp;");
                for (i = 1; i < hold_len; i++) run_q = {run_q, cand[i]};
                hold_len = 3'd0;
                take_fresh(b, eot);
            end
        end
    endtask

    // Move run_q into the expected store with its flags
    task automatic queue_run(input logic eot);
        t_esc_byte x;
        foreach (run_q[i]) begin
            x.ch   = run_q[i];
            x.last = (i == run_q.size() - 1);
            x.done = x.last && eot;
            esc_q  = {esc_q, x};
        end
        run_q.delete();
    endtask

    // Offer one transaction; called at a falling edge, returns at one
    task automatic offer(input logic [7:0] b, input logic eot, input bit typed,
                         input string text);
        int i;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid    <= 1'b0;
            i_in_byte     <= 8'($urandom);
            i_end_of_text <= 1'($urandom);
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_byte     <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_in_stall);
        escape_step(b, eot);
        if (typed) begin
            run_q.delete();
            for (i = 0; i < text.len(); i++) run_q = {run_q, text[i]};
        end
        queue_run(eot);
        @(negedge i_clk);
    endtask

    // Sender pauses until every expected byte has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (esc_q.size() != 0) @(negedge i_clk);
    endtask

    // Random string: mostly entities, entity prefixes and specials
    task automatic build_text();
        int    pieces;
        int    k;
        int    i;
        int    r;
        int    n;
        string spell;
        string specials = "\"<>&";
        string letters  = "lgtampquo;";
        txt_q.delete();
        pieces = $urandom_range(6, 1);
        for (k = 0; k < pieces; k++) begin
            r     = $urandom_range(99);
            spell = ent_spell[$urandom_range(3)];
            if (r < 25) begin
                for (i = 0; i < spell.len(); i++) txt_q = {txt_q, spell[i]};
            end else if (r < 45) begin
                n = $urandom_range(spell.len() - 2, 0);
                for (i = 0; i <= n; i++) txt_q = {txt_q, spell[i]};
            end else if (r < 60) begin
                txt_q = {txt_q, specials[$urandom_range(3)]};
            end else if (r < 75) begin
                txt_q = {txt_q, letters[$urandom_range(letters.len() - 1)]};
            end else begin
                txt_q = {txt_q, 8'($urandom_range(255))};
            end
        end
    endtask

    // Output side: random stall, or a long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Output checker and watchdog
    always @(posedge i_clk) begin
        t_esc_byte want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (esc_q.size() == 0) begin
                    $error("unexpected output byte %02h", o_out_byte);
                    mismatches++;
                end else begin
                    want = esc_q.pop_front();
                    if (o_out_byte !== want.ch) begin
                        $error("out_byte: expected %02h, got %02h", want.ch, o_out_byte);
                        mismatches++;
                    end
                    if (o_run_last !== want.last) begin
                        $error("run_last: expected %0b, got %0b", want.last, o_run_last);
                        mismatches++;
                    end
                    if (o_text_done !== want.done) begin
                        $error("text_done: expected %0b, got %0b", want.done, o_text_done);
                        mismatches++;
                    end
                end
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        int p;
        int n;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_byte      = 8'h00;
        i_end_of_text  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        mismatches     = 0;
        quiet_cycles   = 0;
        hold_len       = 3'd0;
        foreach (hold_buf[i]) hold_buf[i] = 8'h00;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (dir_rows[r])
            offer(dir_rows[r].ch, dir_rows[r].eot, dir_rows[r].typed, dir_rows[r].text);
        wait_drained();

        // random strings under four idling regimes
        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            n = 0;
            while (n < PHASE_ITEMS) begin
                build_text();
                foreach (txt_q[k]) begin
                    // back up the output while input keeps coming
                    if (p == 0 && n == 20) hold_req = 1'b1;
                    offer(txt_q[k], (k == txt_q.size() - 1), 1'b0, "");
                    n++;
                end
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/xe_pkg.sv
rtl/xe_front.sv
rtl/xe_fifo.sv
rtl/xe_back.sv
rtl/xml_entity_escaper.sv
sim/tb.sv
